>>> rtl/bfa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfa_pkg;

   // Geometry of the used-frame bitmap
   localparam int MAX_FRAMES = 4096;
   localparam int WORD_BITS  = 32;
   localparam int BIT_W      = 5;
   localparam int MAP_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   // Address and register widths
   localparam int ADDR_W     = 32;
   localparam int PAGE_SHIFT = 12;
   localparam int FRAME_W    = ADDR_W - PAGE_SHIFT;
   localparam int USABLE_W   = 13;
   localparam int RESERVED_W = 20;
   localparam int CSR_DATA_W = 20;
   localparam int CSR_IDX_W  = 1;
   localparam int MAXCNT_W   = $clog2(MAX_FRAMES + 1);
   localparam int CNT_W      = (MAXCNT_W > USABLE_W) ? MAXCNT_W : USABLE_W;
   localparam int CMP_W      = (CNT_W > FRAME_W) ? CNT_W : FRAME_W;

   localparam logic [USABLE_W-1:0]   USABLE_RESET   = USABLE_W'(4096);
   localparam logic [RESERVED_W-1:0] RESERVED_RESET = RESERVED_W'(256);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_USABLE   = 1'b0,
      CSR_RESERVED = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_FREE_RD,
      S_FREE_WR,
      S_DONE
   } state_type;

   // Bitmap port request from the sequencer
   typedef struct packed {
      logic                 rd_en;
      logic [WADDR_W-1:0]   rd_addr;
      logic                 wr_en;
      logic [WADDR_W-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } map_req_type;

   // Finished result handed to the output register
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] frame_address;
      status_type        status;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/bfa_map.sv
`timescale 1ns / 1ps
`default_nettype none
module bfa_map (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire bfa_pkg::map_req_type          req,
   output logic [bfa_pkg::WORD_BITS-1:0]      rd_data
);
   import bfa_pkg::*;

   logic [WORD_BITS-1:0] map_ff [MAP_WORDS];
   logic [MAP_WORDS-1:0] row_valid_ff;
   logic [WORD_BITS-1:0] rd_word_ff;
   logic                 rd_hit_ff;

   // Track written rows; an unwritten row reads as all free
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_hit_ff    <= 1'b0;
      end else begin
         if (req.wr_en) begin
            row_valid_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            rd_hit_ff <= row_valid_ff[req.rd_addr];
         end
      end
   end

   // Bitmap storage with registered read
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         map_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_word_ff <= map_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_hit_ff ? rd_word_ff : '0;

endmodule
`default_nettype wire

>>> rtl/bfa_find.sv
`timescale 1ns / 1ps
`default_nettype none
module bfa_find (
   input  wire logic [bfa_pkg::WORD_BITS-1:0] word,
   input  wire logic [bfa_pkg::WORD_BITS-1:0] mask,
   output logic                               found,
   output logic [bfa_pkg::BIT_W-1:0]          bit_pos
);
   import bfa_pkg::*;

   logic [WORD_BITS-1:0] free_bits;

   assign free_bits = ~word & mask;
   assign found     = |free_bits;

   // Pick the lowest free bit inside the mask
   always_comb begin
      bit_pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            bit_pos = BIT_W'(i);
         end
      end
   end

endmodule
`default_nettype wire

>>> rtl/bfa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module bfa_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic                           op,
   input  wire logic [bfa_pkg::ADDR_W-1:0]     free_address,
   input  wire logic [bfa_pkg::CNT_W-1:0]      limit,
   input  wire logic [bfa_pkg::RESERVED_W-1:0] reserved,
   input  wire logic [bfa_pkg::WORD_BITS-1:0]  rd_data,
   input  wire logic                           out_free,
   output logic                                idle,
   output bfa_pkg::map_req_type                map_req,
   output bfa_pkg::result_type                 result
);
   import bfa_pkg::*;

   state_type           state_ff, state_in;
   logic [WADDR_W-1:0]  word_ff, word_in;
   logic [FRAME_W-1:0]  fidx_ff, fidx_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   status_type          status_ff, status_in;

   logic [FRAME_W-1:0]   frame_num;
   logic [FRAME_W-1:0]   rel_idx;
   logic                 below;
   logic                 over;
   logic                 bad_free;
   logic                 limit_zero;
   logic [CNT_W-1:0]     lim_m1;
   logic [WADDR_W-1:0]   last_word;
   logic                 at_last;
   logic [BIT_W-1:0]     tail;
   logic [WORD_BITS-1:0] scan_mask;
   logic                 found;
   logic [BIT_W-1:0]     found_bit;
   logic [FRAME_W-1:0]   alloc_frame;
   logic [WADDR_W-1:0]   free_word;

   // Free range check against the kernel region and the frame count
   assign frame_num  = free_address[ADDR_W-1:PAGE_SHIFT];
   assign below      = frame_num < FRAME_W'(reserved);
   assign rel_idx    = frame_num - FRAME_W'(reserved);
   assign over       = CMP_W'(rel_idx) >= CMP_W'(limit);
   assign bad_free   = below || over;
   assign limit_zero = (limit == '0);

   // Last bitmap word in scope, and the tail mask of that word
   assign lim_m1    = limit - CNT_W'(1);
   assign last_word = lim_m1[BIT_W +: WADDR_W];
   assign at_last   = (word_ff == last_word);
   assign tail      = limit[BIT_W-1:0];
   assign scan_mask = (at_last && tail != '0) ?
                      ((WORD_BITS'(1) << tail) - WORD_BITS'(1)) : '1;

   bfa_find u_find (
      .word    (rd_data),
      .mask    (scan_mask),
      .found   (found),
      .bit_pos (found_bit)
   );

   assign alloc_frame = FRAME_W'({word_ff, found_bit}) + FRAME_W'(reserved);
   assign free_word   = fidx_ff[BIT_W +: WADDR_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff   <= word_in;
      fidx_ff   <= fidx_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (op == OP_ALLOC) begin
                  state_in = limit_zero ? S_DONE : S_SCAN;
               end else begin
                  state_in = bad_free ? S_DONE : S_FREE_RD;
               end
            end
         end
         S_SCAN: begin
            if (found || at_last) begin
               state_in = S_DONE;
            end
         end
         S_FREE_RD: state_in = S_FREE_WR;
         S_FREE_WR: state_in = S_DONE;
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath registers
   always_comb begin
      word_in   = word_ff;
      fidx_in   = fidx_ff;
      addr_in   = addr_ff;
      status_in = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               word_in = '0;
               fidx_in = rel_idx;
               addr_in = '0;
               if (op == OP_ALLOC) begin
                  status_in = limit_zero ? ST_FULL : ST_OK;
               end else begin
                  status_in = bad_free ? ST_RANGE : ST_OK;
               end
            end
         end
         S_SCAN: begin
            if (found) begin
               addr_in   = {alloc_frame, PAGE_SHIFT'(0)};
               status_in = ST_OK;
            end else if (at_last) begin
               addr_in   = '0;
               status_in = ST_FULL;
            end else begin
               word_in = word_ff + WADDR_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Outputs: bitmap port, ready and result
   always_comb begin
      map_req = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start && op == OP_ALLOC && !limit_zero) begin
               map_req.rd_en   = 1'b1;
               map_req.rd_addr = '0;
            end
         end
         S_SCAN: begin
            if (found) begin
               map_req.wr_en   = 1'b1;
               map_req.wr_addr = word_ff;
               map_req.wr_data = rd_data | (WORD_BITS'(1) << found_bit);
            end else if (!at_last) begin
               map_req.rd_en   = 1'b1;
               map_req.rd_addr = word_ff + WADDR_W'(1);
            end
         end
         S_FREE_RD: begin
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = free_word;
         end
         S_FREE_WR: begin
            map_req.wr_en   = 1'b1;
            map_req.wr_addr = free_word;
            map_req.wr_data = rd_data & ~(WORD_BITS'(1) << fidx_ff[BIT_W-1:0]);
         end
         default: begin
         end
      endcase
   end

   assign idle                 = (state_ff == S_IDLE);
   assign result.valid         = (state_ff == S_DONE) && out_free;
   assign result.frame_address = addr_ff;
   assign result.status        = status_ff;

endmodule
`default_nettype wire

>>> rtl/bitmap_frame_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// First-fit page-frame allocator over a used-frame bitmap of 128 words of 32 bits held
// in a single-port-style memory. One request is processed at a time. An allocate reads
// the bitmap one word per cycle from frame 0 up, hands each word to one shared
// lowest-free-bit finder and stops at the first hit or at the last word below the frame
// count. A free does a read-modify-write of one word; a free outside the allocatable
// window, or an allocate with a zero frame count, skips the bitmap. In each case the
// result word shows up in the same cycle as the next request can be taken. The result
// sits in an output register, so a new request can be taken while it waits.
// Configuration is to be written through the csr port while no request is in flight;
// the block does not enforce this. The bitmap reads as all free after reset with no
// clearing pass.
module bitmap_frame_allocator (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [31:0]                    req_tdata,  // [31:0] free_address
   input  wire logic [0:0]                     req_tuser,  // [0] op
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [31:0]                         rsp_tdata,  // [31:0] frame_address
   output logic [1:0]                          rsp_tuser,  // [1:0] status
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [bfa_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [bfa_pkg::CSR_DATA_W-1:0] csr_data
);
   import bfa_pkg::*;

   logic [USABLE_W-1:0]   usable_ff;
   logic [RESERVED_W-1:0] reserved_ff;
   logic [CNT_W-1:0]      limit;

   logic                  rsp_valid_ff;
   logic [ADDR_W-1:0]     rsp_addr_ff;
   status_type            rsp_status_ff;

   logic                  idle;
   logic                  start;
   logic                  out_free;
   map_req_type           map_req;
   logic [WORD_BITS-1:0]  rd_data;
   result_type            result;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         usable_ff   <= USABLE_RESET;
         reserved_ff <= RESERVED_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_USABLE:   usable_ff   <= csr_data[USABLE_W-1:0];
            CSR_RESERVED: reserved_ff <= csr_data[RESERVED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Saturate the frame count at the bitmap size
   assign limit = (CNT_W'(usable_ff) > CNT_W'(MAX_FRAMES)) ?
                  CNT_W'(MAX_FRAMES) : CNT_W'(usable_ff);

   assign req_tready = idle;
   assign start      = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   bfa_map u_map (
      .clock   (clock),
      .reset   (reset),
      .req     (map_req),
      .rd_data (rd_data)
   );

   bfa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .op           (req_tuser[0]),
      .free_address (req_tdata),
      .limit        (limit),
      .reserved     (reserved_ff),
      .rd_data      (rd_data),
      .out_free     (out_free),
      .idle         (idle),
      .map_req      (map_req),
      .result       (result)
   );

   // Output register: load a finished word, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (result.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_addr_ff   <= result.frame_address;
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule
`default_nettype wire

>>> rtl/bfa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module bfa_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   input  wire logic                           req_tready,
   input  wire logic                           rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic [31:0]                    rsp_tdata,
   input  wire logic [1:0]                     rsp_tuser
);
   import bfa_pkg::*;

   // A stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // One request at a time: the block is busy right after taking a word
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a previous one is in flight");

   // Status is one of the defined codes
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_OK || rsp_tuser == ST_FULL || rsp_tuser == ST_RANGE))
      else $error("undefined status code");

   // Failed or rejected requests return address zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_FULL || rsp_tuser == ST_RANGE) |-> rsp_tdata == '0)
      else $error("nonzero address on a failed request");

   // Returned addresses are page aligned
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[PAGE_SHIFT-1:0] == '0)
      else $error("frame address not page aligned");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);
`default_nettype wire
